FILE: rtl/core/rlh_pkg.sv
package rlh_pkg;

	// input item commands
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BOX_X_MIN    = 3'd2;
	localparam logic [2:0] REG_BOX_X_MAX    = 3'd3;
	localparam logic [2:0] REG_BOX_Y_MIN    = 3'd4;
	localparam logic [2:0] REG_BOX_Y_MAX    = 3'd5;
	localparam logic [2:0] REG_NONE         = 3'd7;

	localparam int LANES    = 4;   // red, green, blue, luma
	localparam int ROWS     = 256; // one row holds bins 2v and 2v+1
	localparam int ROW_W    = 8;
	localparam int COL_W    = 13;
	localparam int DIM_W    = 14;
	localparam int SAMPLE_W = 20;
	localparam int CLAMP_W  = 17;
	localparam int OUT_W    = 32;

	// bt.709 coefficients in q16
	localparam logic [13:0] COEF_R = 14'd13933;
	localparam logic [15:0] COEF_G = 16'd46871;
	localparam logic [12:0] COEF_B = 13'd4732;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PX_MUL,
		ST_PX_SUM,
		ST_PX_RD,
		ST_PX_WR,
		ST_BIN_RD,
		ST_BIN_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic load;
		logic px_load;
		logic mul;
		logic sum;
		logic rd_px;
		logic wr_px;
		logic rd_bin;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/core/rlh_ram.sv
module rlh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/rlh_ctrl.sv
module rlh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	output rlh_pkg::ctrl_cmd_t  ctrl,
	input  rlh_pkg::dp_status_t status
);
	import rlh_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_PIXEL) begin
						state_d = ST_PX_MUL;
					end else if (cmd == CMD_READ) begin
						state_d = ST_BIN_RD;
					end
				end
			end
			ST_PX_MUL:  state_d = ST_PX_SUM;
			ST_PX_SUM:  state_d = ST_PX_RD;
			ST_PX_RD:   state_d = ST_PX_WR;
			ST_PX_WR:   state_d = ST_IDLE;
			ST_BIN_RD:  state_d = ST_BIN_OUT;
			ST_BIN_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.load     = accept;
				ctrl.clear    = accept && (cmd == CMD_CLEAR);
				ctrl.px_load  = accept && (cmd == CMD_PIXEL);
			end
			ST_PX_MUL:  ctrl.mul      = 1'b1;
			ST_PX_SUM:  ctrl.sum      = 1'b1;
			ST_PX_RD:   ctrl.rd_px    = 1'b1;
			ST_PX_WR:   ctrl.wr_px    = 1'b1;
			ST_BIN_RD:  ctrl.rd_bin   = 1'b1;
			ST_BIN_OUT: ctrl.out_load = status.out_free;
			default:    ctrl = '0;
		endcase
	end

endmodule

FILE: rtl/core/rlh_datapath.sv
module rlh_datapath #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rlh_pkg::ctrl_cmd_t                  ctrl,
	output rlh_pkg::dp_status_t                 status,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [13:0]                         cfg_data,
	input  logic signed [rlh_pkg::SAMPLE_W-1:0] red_sample,
	input  logic signed [rlh_pkg::SAMPLE_W-1:0] green_sample,
	input  logic signed [rlh_pkg::SAMPLE_W-1:0] blue_sample,
	input  logic [8:0]                          read_bin,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rlh_pkg::OUT_W-1:0]           red_count,
	output logic [rlh_pkg::OUT_W-1:0]           green_count,
	output logic [rlh_pkg::OUT_W-1:0]           blue_count,
	output logic [rlh_pkg::OUT_W-1:0]           luma_count
);
	import rlh_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [CLAMP_W-1:0]     ONE_Q16   = CLAMP_W'(65536);

	// configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic [COL_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			x_min_q  <= '0;
			x_max_q  <= '1;
			y_min_q  <= '0;
			y_max_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_BOX_X_MIN:    x_min_q  <= cfg_data[COL_W-1:0];
				REG_BOX_X_MAX:    x_max_q  <= cfg_data[COL_W-1:0];
				REG_BOX_Y_MIN:    y_min_q  <= cfg_data[COL_W-1:0];
				REG_BOX_Y_MAX:    y_max_q  <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position and box test
	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             in_frame, in_box, wrap;
	logic             count_en_q;

	assign in_frame = (row_q < height_q) && !row_q[DIM_W-1];
	assign in_box   = (col_q >= x_min_q) && (col_q <= x_max_q) &&
	                  (row_q[COL_W-1:0] >= y_min_q) && (row_q[COL_W-1:0] <= y_max_q);
	assign wrap     = ({1'b0, col_q} + DIM_W'(1) >= width_q) || (col_q == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			count_en_q <= 1'b0;
		end else if (ctrl.clear) begin
			col_q      <= '0;
			row_q      <= '0;
		end else if (ctrl.px_load) begin
			count_en_q <= in_frame && in_box;
			if (in_frame) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= row_q + DIM_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// clamp to 0..1.0
	function automatic logic [CLAMP_W-1:0] clamp_q16(input logic [SAMPLE_W-1:0] s);
		logic [CLAMP_W-1:0] r;
		if (s[SAMPLE_W-1]) begin
			r = '0;
		end else if (s > SAMPLE_W'(ONE_Q16)) begin
			r = ONE_Q16;
		end else begin
			r = s[CLAMP_W-1:0];
		end
		return r;
	endfunction

	// round a clamped sample to 8 bits: (c*255 + 0.5) >> 16
	function automatic logic [ROW_W-1:0] to_8bit(input logic [CLAMP_W-1:0] c);
		logic [24:0] t;
		t = ({c, 8'd0} - {8'd0, c}) + 25'd32768;
		return t[23:16];
	endfunction

	// stage 1: clamped samples, taken at transfer
	logic [CLAMP_W-1:0] rc_s1, gc_s1, bc_s1;
	logic [8:0]         bin_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rc_s1 <= clamp_q16(red_sample);
			gc_s1 <= clamp_q16(green_sample);
			bc_s1 <= clamp_q16(blue_sample);
			bin_q <= read_bin;
		end
	end

	// stage 2: color bins and luma products
	// stage 3: luma sum, scale by 255, round
	logic [ROW_W-1:0] v_s2 [LANES];
	logic [30:0]      pr_s2, pb_s2;
	logic [31:0]      pg_s2;
	logic [32:0]      lsum;
	logic [40:0]      lscaled;

	assign lsum    = 33'(pr_s2) + 33'(pg_s2) + 33'(pb_s2);
	assign lscaled = ({lsum, 8'd0} - {8'd0, lsum}) + 41'h80000000;

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			v_s2[0] <= to_8bit(rc_s1);
			v_s2[1] <= to_8bit(gc_s1);
			v_s2[2] <= to_8bit(bc_s1);
			pr_s2   <= 31'(rc_s1) * 31'(COEF_R);
			pg_s2   <= 32'(gc_s1) * 32'(COEF_G);
			pb_s2   <= 31'(bc_s1) * 31'(COEF_B);
		end
		if (ctrl.sum) begin
			v_s2[3] <= lscaled[39:32];
		end
	end

	// histogram stores, one row per pair of bins
	logic [COUNT_WIDTH-1:0] sel_cnt [LANES];

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [ROWS-1:0]          vld_q;
		logic                     rd_vld_q;
		logic [ROW_W-1:0]         rd_addr;
		logic [2*COUNT_WIDTH-1:0] rd_data;
		logic [COUNT_WIDTH-1:0]   lo, hi, lo_inc, hi_inc;
		logic                     we;

		assign rd_addr = ctrl.rd_bin ? bin_q[8:1] : v_s2[i];
		assign lo      = rd_vld_q ? rd_data[COUNT_WIDTH-1:0] : '0;
		assign hi      = rd_vld_q ? rd_data[2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
		assign lo_inc  = (lo == COUNT_MAX) ? lo : lo + COUNT_WIDTH'(1);
		assign hi_inc  = (hi == COUNT_MAX) ? hi : hi + COUNT_WIDTH'(1);
		assign we      = ctrl.wr_px && count_en_q;
		assign sel_cnt[i] = bin_q[0] ? hi : lo;

		// row valid bits, cleared together by a clear command
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= '0;
			end else if (ctrl.clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[v_s2[i]] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.rd_px || ctrl.rd_bin) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end

		rlh_ram #(
			.WIDTH(2*COUNT_WIDTH),
			.DEPTH(ROWS)
		) u_ram (
			.clk    (clk),
			.wr_en  (we),
			.wr_addr(v_s2[i]),
			.wr_data({hi_inc, lo_inc}),
			.rd_en  (ctrl.rd_px || ctrl.rd_bin),
			.rd_addr(rd_addr),
			.rd_data(rd_data)
		);
	end

	// output register
	logic out_valid_q;

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			red_count   <= OUT_W'(sel_cnt[0]);
			green_count <= OUT_W'(sel_cnt[1]);
			blue_count  <= OUT_W'(sel_cnt[2]);
			luma_count  <= OUT_W'(sel_cnt[3]);
		end
	end

endmodule

FILE: rtl/core/rgb_luma_histogram_accumulator.sv
// channel  | handshake           | payload
// ---------+---------------------+------------------------------------------------
// in       | in_valid, in_stall  | cmd, red/green/blue_sample, read_bin
// out      | out_valid, out_stall| red/green/blue/luma_count
// cfg      | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// a pixel passes through transfer, multiply, luma sum, bin read and bin write,
// in order, for the read-modify-write through the registered-read bin memories.
// a bin read passes through transfer, bin read and output, with any wait for the
// output register; a clear resets the row valid bits at once (no memory sweep).
// reset empties all bins, the raster position and the output register.
// out_stall holds the result; in_stall is high while an item is in work.
module rgb_luma_histogram_accumulator #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          cmd,
	input  logic signed [rlh_pkg::SAMPLE_W-1:0] red_sample,
	input  logic signed [rlh_pkg::SAMPLE_W-1:0] green_sample,
	input  logic signed [rlh_pkg::SAMPLE_W-1:0] blue_sample,
	input  logic [8:0]                          read_bin,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rlh_pkg::OUT_W-1:0]           red_count,
	output logic [rlh_pkg::OUT_W-1:0]           green_count,
	output logic [rlh_pkg::OUT_W-1:0]           blue_count,
	output logic [rlh_pkg::OUT_W-1:0]           luma_count,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [13:0]                         cfg_data
);
	import rlh_pkg::*;

	ctrl_cmd_t  ctrl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rlh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.ctrl    (ctrl),
		.status  (status)
	);

	rlh_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.red_sample  (red_sample),
		.green_sample(green_sample),
		.blue_sample (blue_sample),
		.read_bin    (read_bin),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red_count   (red_count),
		.green_count (green_count),
		.blue_count  (blue_count),
		.luma_count  (luma_count)
	);

endmodule

FILE: sim/rgb_luma_histogram_checker.sv
module rgb_luma_histogram_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [19:0] red_sample,
	input  logic [19:0] green_sample,
	input  logic [19:0] blue_sample,
	input  logic [8:0]  read_bin,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] red_count,
	input  logic [31:0] green_count,
	input  logic [31:0] blue_count,
	input  logic [31:0] luma_count,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rlh_pkg::*;

	typedef struct packed {
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		logic [31:0] y;
	} counts_t;

	logic [31:0] hist_r [512];
	logic [31:0] hist_g [512];
	logic [31:0] hist_b [512];
	logic [31:0] hist_y [512];
	logic [13:0] width_q, height_q;
	logic [12:0] x_lo, x_hi, y_lo, y_hi;
	int unsigned col, row;
	counts_t expected_reads [$];

	function automatic logic [16:0] clamp_sample(logic [19:0] s);
		if (s[19]) return '0;
		if (s > 20'd65536) return 17'd65536;
		return s[16:0];
	endfunction

	function automatic logic [7:0] to_byte(logic [16:0] c);
		logic [40:0] t;
		t = c * 41'd255 + 41'd32768;
		return t[23:16];
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	task automatic bump_bins(ref logic [31:0] h [512], input logic [7:0] v);
		h[{v, 1'b0}] = sat_inc(h[{v, 1'b0}]);
		h[{v, 1'b1}] = sat_inc(h[{v, 1'b1}]);
	endtask

	task automatic clear_histograms();
		for (int i = 0; i < 512; i++) begin
			hist_r[i] = '0; hist_g[i] = '0; hist_b[i] = '0; hist_y[i] = '0;
		end
		col = 0;
		row = 0;
	endtask

	// apply one pixel to the predicted histograms
	task automatic accumulate_pixel(logic [19:0] rs, logic [19:0] gs, logic [19:0] bs);
		logic [16:0] rc, gc, bc;
		logic [63:0] lsum;
		logic [7:0] luma;
		if (row >= height_q || row >= 8192) return;
		if (col >= x_lo && col <= x_hi && row >= y_lo && row <= y_hi) begin
			rc = clamp_sample(rs);
			gc = clamp_sample(gs);
			bc = clamp_sample(bs);
			bump_bins(hist_r, to_byte(rc));
			bump_bins(hist_g, to_byte(gc));
			bump_bins(hist_b, to_byte(bc));
			lsum = 64'(rc) * 64'd13933 + 64'(gc) * 64'd46871 + 64'(bc) * 64'd4732;
			lsum = lsum * 64'd255 + 64'h8000_0000;
			luma = lsum[39:32];
			bump_bins(hist_y, luma);
		end
		if (col + 1 >= width_q || col >= 8191) begin
			col = 0;
			row++;
		end else begin
			col++;
		end
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		counts_t got, exp_c;
		if (!arst_n) begin
			clear_histograms();
			width_q = 14'd1; height_q = 14'd1;
			x_lo = '0; x_hi = 13'd8191; y_lo = '0; y_hi = 13'd8191;
			expected_reads.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{red_count, green_count, blue_count, luma_count};
				if (expected_reads.size() == 0) begin
					$display("%0t: unexpected result r=%0d g=%0d b=%0d y=%0d", $time,
						got.r, got.g, got.b, got.y);
					fail_count <= fail_count + 1;
				end else begin
					exp_c = expected_reads.pop_front();
					if (got !== exp_c) begin
						$display("%0t: count mismatch expected r=%0d g=%0d b=%0d y=%0d",
							$time, exp_c.r, exp_c.g, exp_c.b, exp_c.y);
						$display("%0t:                  actual r=%0d g=%0d b=%0d y=%0d",
							$time, got.r, got.g, got.b, got.y);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_CLEAR: clear_histograms();
					CMD_PIXEL: accumulate_pixel(red_sample, green_sample, blue_sample);
					CMD_READ: expected_reads.insert(expected_reads.size(),
						counts_t'{hist_r[read_bin], hist_g[read_bin], hist_b[read_bin],
						hist_y[read_bin]});
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q = cfg_data;
					REG_IMAGE_HEIGHT: height_q = cfg_data;
					REG_BOX_X_MIN:    x_lo = cfg_data[12:0];
					REG_BOX_X_MAX:    x_hi = cfg_data[12:0];
					REG_BOX_Y_MIN:    y_lo = cfg_data[12:0];
					REG_BOX_Y_MAX:    y_hi = cfg_data[12:0];
					default: ;
				endcase
			end
			pending <= expected_reads.size();
		end
	end
endmodule

FILE: sim/tb_rgb_luma_histogram_accumulator.sv
module tb_rgb_luma_histogram_accumulator;
	timeunit 1ns;
	timeprecision 1ps;
	import rlh_pkg::*;

	logic        clk, arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [1:0]  cmd;
	logic signed [19:0] red_sample, green_sample, blue_sample;
	logic [8:0]  read_bin;
	logic [31:0] red_count, green_count, blue_count, luma_count;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;
	int          fail_count, pending;
	int          send_idle_pct, recv_stall_pct;

	rgb_luma_histogram_accumulator uut (.*);
	rgb_luma_histogram_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver stall, random per phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// one sample value, biased toward the clamp edges and the q16 range
	function automatic logic [19:0] pick_sample();
		case ($urandom_range(7))
			0: return 20'h80000;
			1: return 20'h7FFFF;
			2: return 20'd65536;
			3: return 20'd65537;
			4: return 20'($urandom);
			5: return 20'hFFFFF;
			default: return 20'($urandom_range(65536));
		endcase
	endfunction

	// valid stays up from one transfer into the next unless the sender idles
	task automatic send_item(logic [1:0] c, logic [19:0] r, logic [19:0] g,
			logic [19:0] b, logic [8:0] bin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		red_sample <= r;
		green_sample <= g;
		blue_sample <= b;
		read_bin <= bin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_pixel();
		send_item(CMD_PIXEL, pick_sample(), pick_sample(), pick_sample(), 9'($urandom));
	endtask

	task automatic send_read(logic [8:0] bin);
		send_item(CMD_READ, 20'($urandom), 20'($urandom), 20'($urandom), bin);
	endtask

	// drain expected reads, then let in-flight pixels finish
	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [13:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_frame(logic [13:0] w, logic [13:0] h, logic [12:0] xl,
			logic [12:0] xh, logic [12:0] yl, logic [12:0] yh);
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_BOX_X_MIN, 14'(xl));
		write_reg(REG_BOX_X_MAX, 14'(xh));
		write_reg(REG_BOX_Y_MIN, 14'(yl));
		write_reg(REG_BOX_Y_MAX, 14'(yh));
		cfg_valid <= 0;
	endtask

	// a frame of random pixels, clears and nops, with reads of random and busy bins
	task automatic run_frame(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: send_item(CMD_CLEAR, 20'($urandom), 20'($urandom), 20'($urandom),
					9'($urandom));
				1: send_item(CMD_NOP, 20'($urandom), 20'($urandom), 20'($urandom),
					9'($urandom));
				2, 3, 4, 5: send_read(9'($urandom));
				6: send_read({$urandom_range(1) ? 8'd255 : 8'd0, 1'($urandom)});
				default: send_pixel();
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0; cmd = CMD_CLEAR;
		red_sample = 0; green_sample = 0; blue_sample = 0; read_bin = 0;
		cfg_valid = 0; cfg_index = REG_IMAGE_WIDTH; cfg_data = 0;
		out_stall = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset geometry takes one pixel, then ignores the rest
		send_item(CMD_PIXEL, 20'd65536, 20'd65536, 20'd65536, 9'd0);
		send_item(CMD_PIXEL, 20'd0, 20'd0, 20'd0, 9'd0);
		send_read(9'd510);
		send_read(9'd511);
		send_read(9'd0);
		send_item(CMD_CLEAR, 20'd0, 20'd0, 20'd0, 9'd0);
		send_item(CMD_PIXEL, 20'h80000, 20'h7FFFF, 20'd32768, 9'd0);
		send_item(CMD_NOP, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 9'h1FF);
		send_read(9'd0);
		send_read(9'd511);
		send_read(9'd256);
		send_read(9'd257);
		set_frame(14'd4, 14'd3, 13'd1, 13'd2, 13'd1, 13'd1);
		send_item(CMD_CLEAR, 20'd0, 20'd0, 20'd0, 9'd0);
		for (int i = 0; i < 14; i++) send_pixel();
		send_read(9'd511);
		// zero width and height, inverted box
		set_frame(14'd0, 14'd0, 13'd5, 13'd2, 13'd8191, 13'd0);
		send_item(CMD_CLEAR, 20'd0, 20'd0, 20'd0, 9'd0);
		send_pixel();
		send_read(9'd0);

		// random phases across geometries and idling
		for (int p = 0; p < 16; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			case (p % 8)
				0: set_frame(14'd8192, 14'd8192, 13'd0, 13'd8191, 13'd0, 13'd8191);
				1: set_frame(14'd1, 14'd16383, 13'd0, 13'd0, 13'd3, 13'd40);
				2: set_frame(14'd16383, 14'd1, 13'd0, 13'd8191, 13'd0, 13'd0);
				3: set_frame(14'($urandom_range(1, 12)), 14'($urandom_range(1, 12)),
					13'($urandom_range(6)), 13'($urandom_range(3, 12)),
					13'($urandom_range(4)), 13'($urandom_range(2, 12)));
				4: set_frame(14'd0, 14'd8, 13'd8191, 13'd8191, 13'd0, 13'd8191);
				5: set_frame(14'd7, 14'd5, 13'd0, 13'd8191, 13'd0, 13'd8191);
				default: set_frame(14'($urandom), 14'($urandom), 13'($urandom_range(8)),
					13'($urandom), 13'($urandom_range(8)), 13'($urandom));
			endcase
			send_item(CMD_CLEAR, 20'd0, 20'd0, 20'd0, 9'd0);
			run_frame(100);
			// hold the sender until all reads are back
			if (p == 5) wait_drained();
		end
		// extra register index is ignored
		wait_drained();
		write_reg(REG_NONE, 14'h3FFF);
		cfg_valid <= 0;
		send_read(9'd1);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
